/* design/murmur2_utf16_string_hash_macros.svh */
// Assertion macros for the UTF-16 MurmurHash2 block and its checker.
// No dependencies; included by the checker file.
`ifndef MURMUR2_UTF16_STRING_HASH_MACROS_SVH
`define MURMUR2_UTF16_STRING_HASH_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define MMH2_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define MMH2_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

/* design/mmh2_pkg.sv */
// Shared types and constants for the UTF-16 MurmurHash2 block.
// No dependencies; imported by every RTL module of the block except mmh2_queue.
package mmh2_pkg;

   localparam int MMH2_HASH_W  = 32;
   localparam int MMH2_LEN_W   = 24;
   localparam int MMH2_UNITS_W = 2;
   localparam int MMH2_BYTES_W = MMH2_LEN_W + 1;

   localparam logic [MMH2_HASH_W-1:0] MMH2_MUL = 32'h5bd1e995;
   localparam int MMH2_MIX_SHIFT  = 24;
   localparam int MMH2_FIN_SHIFT_A = 13;
   localparam int MMH2_FIN_SHIFT_B = 15;

   // Queue depths, powers of two, at least two
   localparam int MMH2_CMD_DEPTH = 4;
   localparam int MMH2_RSP_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_UNIT,
      KIND_FULL
   } mmh2_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_K1,
      BK_K2,
      BK_H,
      BK_UNIT,
      BK_FIN
   } mmh2_state_type;

   typedef struct packed {
      logic [MMH2_HASH_W-1:0]  word;
      mmh2_kind_type           kind;
      logic                    first;
      logic                    last;
      logic [MMH2_BYTES_W-1:0] len_bytes;
   } mmh2_entry_type;

endpackage

/* design/murmur2_utf16_string_hash.sv */
// 32-bit MurmurHash2 (seed zero) over strings of UTF-16 code units.
// Requests: req_push/req_full queue, two code units per request in req_word
// (first unit in bits 15..0), req_units valid units, req_first starts a string
// and loads twice req_length_units, req_last finalises and emits one result.
// Results: rsp_empty/rsp_pop queue; rsp_hash holds the oldest waiting hash.
// A request is taken from a four-entry queue by the back end, which shares a
// single 32x32 multiplier: a dequeue step, then multiply steps K1, K2 and H
// for a full word, the BK_UNIT multiply step for a lone unit, none for an empty
// request, and a finalise step on the last request. The back end takes no new
// request until it is through with the one before; sustained rate is set by the multiplier sequencer.
// When the result queue fills the back end holds in its finalise
// step, then the request queue fills and req_full rises; nothing is dropped.
// Reset (synchronous) empties both queues and clears the running hash to zero.
// Depends on mmh2_pkg, mmh2_front, mmh2_back and mmh2_queue.
module murmur2_utf16_string_hash import mmh2_pkg::*; #(
   parameter int CMD_DEPTH = MMH2_CMD_DEPTH,
   parameter int RSP_DEPTH = MMH2_RSP_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [MMH2_HASH_W-1:0]  req_word,
   input  logic [MMH2_UNITS_W-1:0] req_units,
   input  logic                    req_first,
   input  logic                    req_last,
   input  logic [MMH2_LEN_W-1:0]   req_length_units,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [MMH2_HASH_W-1:0]  rsp_hash
);

   logic                   cmd_pop;
   logic                   cmd_empty;
   mmh2_entry_type         cmd_entry;
   logic                   rsp_push;
   logic                   rsp_full;
   logic [MMH2_HASH_W-1:0] rsp_data;

   mmh2_front #(
      .CMD_DEPTH(CMD_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_word        (req_word),
      .req_units       (req_units),
      .req_first       (req_first),
      .req_last        (req_last),
      .req_length_units(req_length_units),
      .cmd_pop         (cmd_pop),
      .cmd_empty       (cmd_empty),
      .cmd_entry       (cmd_entry)
   );

   mmh2_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd_entry(cmd_entry),
      .cmd_pop  (cmd_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp_data (rsp_data)
   );

   mmh2_queue #(
      .WIDTH(MMH2_HASH_W),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wr_data(rsp_data),
      .full   (rsp_full),
      .pop    (rsp_pop),
      .rd_data(rsp_hash),
      .empty  (rsp_empty)
   );

endmodule

/* design/mmh2_queue.sv */
// Small first-in first-out queue held in flip-flops.
// No dependencies; used for the request queue and the result queue.
module mmh2_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW:0]      rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   // Extra pointer bit tells a full queue from an empty one
   assign empty   = (wr_ptr_ff == rd_ptr_ff);
   assign full    = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                    (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff[AW-1:0]];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= wr_data;
      end
   end

endmodule

/* design/mmh2_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on mmh2_pkg and mmh2_queue.
module mmh2_front import mmh2_pkg::*; #(
   parameter int CMD_DEPTH = MMH2_CMD_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [MMH2_HASH_W-1:0]  req_word,
   input  logic [MMH2_UNITS_W-1:0] req_units,
   input  logic                    req_first,
   input  logic                    req_last,
   input  logic [MMH2_LEN_W-1:0]   req_length_units,
   input  logic                    cmd_pop,
   output logic                    cmd_empty,
   output mmh2_entry_type          cmd_entry
);

   localparam int ENTRY_W = $bits(mmh2_entry_type);

   mmh2_entry_type     entry;
   logic [ENTRY_W-1:0] entry_raw;

   always_comb begin
      entry.word      = req_word;
      entry.first     = req_first;
      entry.last      = req_last;
      entry.len_bytes = {req_length_units, 1'b0};
      case (req_units)
         2'd0:    entry.kind = KIND_NONE;
         2'd1:    entry.kind = KIND_UNIT;
         default: entry.kind = KIND_FULL;   // three counts as a full word
      endcase
   end

   mmh2_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .wr_data(entry),
      .full   (req_full),
      .pop    (cmd_pop),
      .rd_data(entry_raw),
      .empty  (cmd_empty)
   );

   assign cmd_entry = mmh2_entry_type'(entry_raw);

endmodule

/* design/mmh2_back.sv */
// Back end: runs the hash rounds on one shared multiplier and finalises on the last request.
// Depends on mmh2_pkg.
module mmh2_back import mmh2_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   input  mmh2_entry_type         cmd_entry,
   output logic                   cmd_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output logic [MMH2_HASH_W-1:0] rsp_data
);

   mmh2_state_type         state_ff, state_in;
   logic [MMH2_HASH_W-1:0] hash_ff, hash_in;
   logic [MMH2_HASH_W-1:0] k_ff, k_in;
   logic [MMH2_HASH_W-1:0] word_ff;
   logic                   last_ff;
   logic [MMH2_HASH_W-1:0] hash_base;
   logic [MMH2_HASH_W-1:0] mul_a;
   logic [MMH2_HASH_W-1:0] product;

   assign hash_base = cmd_entry.first ? MMH2_HASH_W'(cmd_entry.len_bytes) : hash_ff;
   assign product   = mul_a * MMH2_MUL;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               case (cmd_entry.kind)
                  KIND_FULL: state_in = BK_K1;
                  KIND_UNIT: state_in = BK_UNIT;
                  default:   state_in = cmd_entry.last ? BK_FIN : BK_IDLE;
               endcase
            end
         end
         BK_K1:   state_in = BK_K2;
         BK_K2:   state_in = BK_H;
         BK_H,
         BK_UNIT: state_in = last_ff ? BK_FIN : BK_IDLE;
         BK_FIN:  state_in = rsp_full ? BK_FIN : BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      mul_a    = word_ff;
      hash_in  = hash_ff;
      k_in     = k_ff;
      rsp_data = product ^ (product >> MMH2_FIN_SHIFT_B);
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = !cmd_empty;
            if (!cmd_empty) begin
               hash_in = hash_base;
            end
         end
         BK_K1: begin
            mul_a = word_ff;
            k_in  = product;
         end
         BK_K2: begin
            mul_a = k_ff ^ (k_ff >> MMH2_MIX_SHIFT);
            k_in  = product;
         end
         BK_H: begin
            mul_a   = hash_ff;
            hash_in = product ^ k_ff;
         end
         BK_UNIT: begin
            mul_a   = hash_ff ^ {16'h0000, word_ff[15:0]};
            hash_in = product;
         end
         BK_FIN: begin
            // running hash keeps its unfinalised value
            mul_a    = hash_ff ^ (hash_ff >> MMH2_FIN_SHIFT_A);
            rsp_push = !rsp_full;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         hash_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd_pop) begin
         word_ff <= cmd_entry.word;
         last_ff <= cmd_entry.last;
      end
   end

endmodule

/* design/mmh2_checker.sv */
// Port-level checker for the UTF-16 MurmurHash2 block, bound to the top level.
// Depends on mmh2_pkg and murmur2_utf16_string_hash_macros.svh.
`include "murmur2_utf16_string_hash_macros.svh"

module mmh2_checker import mmh2_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_push,
   input logic                    req_full,
   input logic                    rsp_empty,
   input logic                    rsp_pop,
   input logic [MMH2_HASH_W-1:0]  rsp_hash
);

   // Both queues come out of reset empty
   `MMH2_ASSERT_NEXT(a_rsp_empty_after_reset, clock, 1'b0, reset, rsp_empty, "result after reset")
   `MMH2_ASSERT_NEXT(a_not_full_after_reset, clock, 1'b0, reset, !req_full, "full after reset")

   // A waiting result is neither dropped nor altered until popped
   `MMH2_ASSERT_NEXT(a_rsp_held, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty, "result lost")
   `MMH2_ASSERT_NEXT(a_hash_stable, clock, reset, !rsp_empty && !rsp_pop, $stable(rsp_hash), "hash changed")

   // Request side is only observed here
   `MMH2_ASSERT(a_push_known, clock, reset, !$isunknown(req_push), "request push unknown")

endmodule

bind murmur2_utf16_string_hash mmh2_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_push (req_push),
   .req_full (req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop  (rsp_pop),
   .rsp_hash (rsp_hash)
);
